// ----- rtl/core/mmr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmr_pkg
// Shared types and constants for the MIDI message receiver.
// ----------------------------------------------------------------------------
package mmr_pkg;

    // Kind of message in progress
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PC    = 2'd1,
        KIND_CC    = 2'd2,
        KIND_SYSEX = 2'd3
    } t_kind;

    // Completed event reported with each result item
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PC       = 3'd1,
        EV_CC       = 3'd2,
        EV_SYSEX    = 3'd3,
        EV_SENSE    = 3'd4,
        EV_OVERFLOW = 3'd5
    } t_event;

    localparam logic [7:0] STATUS_BIT   = 8'h80;
    localparam logic [7:0] HI_NIBBLE    = 8'hF0;
    localparam logic [7:0] LO_NIBBLE    = 8'h0F;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_STOP   = 8'hF7;
    localparam logic [7:0] SENSE_CODE   = 8'hFE;
    localparam logic [7:0] PROG_CHG_HI  = 8'hC0;
    localparam logic [7:0] CTRL_CHG_HI  = 8'hB0;

    // Message state apart from the byte count
    typedef struct packed {
        t_kind      kind;
        logic [7:0] status_byte;
        logic [7:0] held_data;
    } t_msg_state;

    // One result item
    typedef struct packed {
        t_event     event_res;
        logic [3:0] channel;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic [8:0] sysex_length;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_byte;
    } t_result;

endpackage

// ----- rtl/core/mmr_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmr_decode
// Per-byte message decode: next message state and the result item.
// ----------------------------------------------------------------------------
module mmr_decode
    import mmr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256,
    parameter int CW           = $clog2(BUFFER_DEPTH + 1)
) (
    input  logic [7:0]    i_byte,
    input  t_msg_state    i_state,
    input  logic [CW-1:0] i_count,
    output t_msg_state    o_state,
    output logic [CW-1:0] o_count,
    output t_result       o_result
);

    localparam int EW = (CW > 9) ? CW : 9;
    localparam logic [CW-1:0] DEPTH = CW'(BUFFER_DEPTH);

    logic          is_status;
    logic [7:0]    hi;
    logic [CW-1:0] cnt_inc;
    logic [EW-1:0] cnt_ext;
    logic [EW-1:0] inc_ext;

    assign is_status = (i_byte & STATUS_BIT) != 8'h00;
    assign hi        = i_byte & HI_NIBBLE;
    assign cnt_inc   = i_count + 1'b1;
    assign cnt_ext   = EW'(i_count);
    assign inc_ext   = EW'(cnt_inc);

    always_comb begin
        o_state  = i_state;
        o_count  = i_count;
        o_result = '0;
        o_result.event_res = EV_NONE;

        if (i_state.kind == KIND_NONE) begin
            if (is_status) begin
                if (hi == PROG_CHG_HI || hi == CTRL_CHG_HI) begin
                    o_state.kind        = (hi == PROG_CHG_HI) ? KIND_PC : KIND_CC;
                    o_state.status_byte = i_byte;
                    o_count             = CW'(1);
                    o_result.store_valid = 1'b1;
                    o_result.store_byte  = i_byte;
                end else if (i_byte == SYSEX_START) begin
                    o_state.kind        = KIND_SYSEX;
                    o_state.status_byte = i_byte;
                    o_count             = CW'(1);
                    o_result.store_valid = 1'b1;
                    o_result.store_byte  = i_byte;
                end else if (i_byte == SENSE_CODE) begin
                    o_state.status_byte  = i_byte;
                    o_result.event_res   = EV_SENSE;
                    o_result.store_valid = 1'b1;
                    o_result.store_byte  = i_byte;
                end
            end
        end else if (is_status && i_byte != SYSEX_STOP) begin
            // abort, drop the byte
            o_state.kind = KIND_NONE;
            o_count      = '0;
        end else if (i_state.kind == KIND_SYSEX) begin
            if (i_count >= DEPTH) begin
                o_result.event_res    = EV_OVERFLOW;
                o_result.sysex_length = cnt_ext[8:0];
                o_state.kind          = KIND_NONE;
                o_count               = '0;
            end else begin
                o_result.store_valid = 1'b1;
                o_result.store_index = cnt_ext[7:0];
                o_result.store_byte  = i_byte;
                o_count              = cnt_inc;
                if (i_byte == SYSEX_STOP) begin
                    o_result.event_res    = EV_SYSEX;
                    o_result.sysex_length = inc_ext[8:0];
                    o_state.kind          = KIND_NONE;
                    o_count               = '0;
                end
            end
        end else begin
            o_result.store_valid = 1'b1;
            o_result.store_index = cnt_ext[7:0];
            o_result.store_byte  = i_byte;
            if (i_state.kind == KIND_PC) begin
                o_result.event_res  = EV_PC;
                o_result.channel    = 4'(i_state.status_byte & LO_NIBBLE);
                o_result.first_data = i_byte;
                o_state.kind        = KIND_NONE;
                o_count             = '0;
            end else if (i_count == CW'(1)) begin
                o_state.held_data = i_byte;
                o_count           = CW'(2);
            end else begin
                o_result.event_res   = EV_CC;
                o_result.channel     = 4'(i_state.status_byte & LO_NIBBLE);
                o_result.first_data  = i_state.held_data;
                o_result.second_data = i_byte;
                o_state.kind         = KIND_NONE;
                o_count              = '0;
            end
        end
    end

endmodule

// ----- rtl/core/midi_message_receiver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_message_receiver
// Parses a MIDI byte stream into program change, control change, sysex,
// sysex overflow and active sense events; every stored byte is reported with its buffer index.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  rx        in         i_rx_valid / o_rx_ready    i_rx_byte
//  res       out        o_res_valid / i_res_ready  o_event_res .. o_store_byte
//
//  One result item per byte, one byte per cycle sustained while the result side is ready.
//  A byte passes through the input register, decode and the result register.
//  The message state updates as a byte moves from input to result register.
//  A stalled result holds; the input register still takes one more byte.
//  Reset (synchronous, active low) empties both registers and goes idle.
// ----------------------------------------------------------------------------
module midi_message_receiver
    import mmr_pkg::*;
#(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [2:0] o_event_res,
    output logic [3:0] o_channel,
    output logic [7:0] o_first_data,
    output logic [7:0] o_second_data,
    output logic [8:0] o_sysex_length,
    output logic       o_store_valid,
    output logic [7:0] o_store_index,
    output logic [7:0] o_store_byte
);

    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic          r_in_vld;
    logic [7:0]    r_in_byte;
    logic          r_out_vld;
    t_result       r_res;
    t_msg_state    r_state;
    logic [CW-1:0] r_count;

    t_msg_state    n_state;
    logic [CW-1:0] n_count;
    t_result       n_res;
    logic          advance;

    assign advance    = r_in_vld && (!r_out_vld || i_res_ready);
    assign o_rx_ready = !r_in_vld || advance;

    mmr_decode #(
        .BUFFER_DEPTH(BUFFER_DEPTH),
        .CW          (CW)
    ) u_decode (
        .i_byte  (r_in_byte),
        .i_state (r_state),
        .i_count (r_count),
        .o_state (n_state),
        .o_count (n_count),
        .o_result(n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '{kind: KIND_NONE, status_byte: 8'h00, held_data: 8'h00};
            r_count   <= '0;
        end else begin
            if (o_rx_ready) begin
                r_in_vld <= i_rx_valid;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
                r_count   <= n_count;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid    = r_out_vld;
    assign o_event_res    = r_res.event_res;
    assign o_channel      = r_res.channel;
    assign o_first_data   = r_res.first_data;
    assign o_second_data  = r_res.second_data;
    assign o_sysex_length = r_res.sysex_length;
    assign o_store_valid  = r_res.store_valid;
    assign o_store_index  = r_res.store_index;
    assign o_store_byte   = r_res.store_byte;

    // idle means nothing counted
    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.kind == KIND_NONE |-> r_count == '0)
        else $error("count not clear while idle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(BUFFER_DEPTH))
        else $error("count beyond buffer depth");

    a_short_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.kind == KIND_PC |-> r_count == CW'(1)) and
        (r_state.kind == KIND_CC |-> (r_count == CW'(1) || r_count == CW'(2))))
        else $error("program or control change count out of range");

    a_event_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (r_res.event_res == EV_PC || r_res.event_res == EV_CC ||
                        r_res.event_res == EV_SYSEX || r_res.event_res == EV_SENSE)
        |-> o_store_valid)
        else $error("completing byte not stored");

    a_overflow_unstored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && r_res.event_res == EV_OVERFLOW |-> !o_store_valid)
        else $error("overflow byte stored");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives a MIDI byte stream into midi_message_receiver and checks every
// result item against a parser model kept inside the bench. The stream has a
// directed opening, then random messages, broken messages and noise. Both
// channels idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import mmr_pkg::*;

    localparam int SYSEX_DEPTH  = 256;
    localparam int TOTAL_BYTES  = 1000;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_LINES = 100;

    // Parser model with the queue of results still to come from the block
    class midi_event_book;
        t_result    pending_events[$];
        int         mismatches;
        int         checked;
        int         stored;
        t_kind      msg_kind;
        logic [7:0] msg_status;
        logic [7:0] msg_held;

        function new();
            mismatches = 0;
            checked    = 0;
            stored     = 0;
            msg_kind   = KIND_NONE;
            msg_status = '0;
            msg_held   = '0;
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction

        function void take_byte(logic [7:0] b);
            t_result r;
            r = '0;
            r.event_res = EV_NONE;
            if (msg_kind == KIND_NONE) begin
                if ((b & STATUS_BIT) != 0) begin
                    if ((b & HI_NIBBLE) == PROG_CHG_HI || (b & HI_NIBBLE) == CTRL_CHG_HI) begin
                        msg_kind   = ((b & HI_NIBBLE) == PROG_CHG_HI) ? KIND_PC : KIND_CC;
                        msg_status = b;
                        stored     = 1;
                        r.store_valid = 1'b1;
                        r.store_byte  = b;
                    end else if (b == SYSEX_START) begin
                        msg_kind   = KIND_SYSEX;
                        msg_status = b;
                        stored     = 1;
                        r.store_valid = 1'b1;
                        r.store_byte  = b;
                    end else if (b == SENSE_CODE) begin
                        msg_status    = b;
                        r.event_res   = EV_SENSE;
                        r.store_valid = 1'b1;
                        r.store_byte  = b;
                    end
                end
            end else if ((b & STATUS_BIT) != 0 && b != SYSEX_STOP) begin
                // abort; the status byte itself is dropped
                msg_kind = KIND_NONE;
                stored   = 0;
            end else if (msg_kind == KIND_SYSEX) begin
                if (stored >= SYSEX_DEPTH) begin
                    r.event_res    = EV_OVERFLOW;
                    r.sysex_length = 9'(stored);
                    msg_kind       = KIND_NONE;
                    stored         = 0;
                end else begin
                    r.store_valid = 1'b1;
                    r.store_index = 8'(stored);
                    r.store_byte  = b;
                    stored++;
                    if (b == SYSEX_STOP) begin
                        r.event_res    = EV_SYSEX;
                        r.sysex_length = 9'(stored);
                        msg_kind       = KIND_NONE;
                        stored         = 0;
                    end
                end
            end else begin
                r.store_valid = 1'b1;
                r.store_index = 8'(stored);
                r.store_byte  = b;
                if (msg_kind == KIND_PC) begin
                    r.event_res  = EV_PC;
                    r.channel    = msg_status[3:0];
                    r.first_data = b;
                    msg_kind     = KIND_NONE;
                    stored       = 0;
                end else if (stored == 1) begin
                    msg_held = b;
                    stored   = 2;
                end else begin
                    r.event_res   = EV_CC;
                    r.channel     = msg_status[3:0];
                    r.first_data  = msg_held;
                    r.second_data = b;
                    msg_kind      = KIND_NONE;
                    stored        = 0;
                end
            end
            pending_events.push_back(r);
        endfunction

        task report(string msg);
            if (mismatches < REPORT_LINES) begin
                $display("%0t mismatch: %s", $realtime, msg);
            end
            mismatches++;
        endtask

        task compare_field(string name, int got, int want);
            if (got != want) begin
                report($sformatf("item %0d %s got %0d want %0d", checked, name, got, want));
            end
        endtask

        task check_event(t_result got);
            t_result want;
            if (pending_events.size() == 0) begin
                report($sformatf("unexpected item, event %0d", got.event_res));
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_res", got.event_res, want.event_res);
            compare_field("channel", got.channel, want.channel);
            compare_field("first_data", got.first_data, want.first_data);
            compare_field("second_data", got.second_data, want.second_data);
            compare_field("sysex_length", got.sysex_length, want.sysex_length);
            compare_field("store_valid", got.store_valid, want.store_valid);
            compare_field("store_index", got.store_index, want.store_index);
            compare_field("store_byte", got.store_byte, want.store_byte);
            checked++;
        endtask
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_rx_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_res_ready = 1'b0;
    logic       o_rx_ready;
    logic       o_res_valid;
    logic [2:0] o_event_res;
    logic [3:0] o_channel;
    logic [7:0] o_first_data;
    logic [7:0] o_second_data;
    logic [8:0] o_sysex_length;
    logic       o_store_valid;
    logic [7:0] o_store_index;
    logic [7:0] o_store_byte;

    midi_event_book book = new();
    int             cycles = 0;
    int             sent   = 0;

    midi_message_receiver #(
        .BUFFER_DEPTH(SYSEX_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .o_event_res   (o_event_res),
        .o_channel     (o_channel),
        .o_first_data  (o_first_data),
        .o_second_data (o_second_data),
        .o_sysex_length(o_sysex_length),
        .o_store_valid (o_store_valid),
        .o_store_index (o_store_index),
        .o_store_byte  (o_store_byte)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = ((cycles / 500) % 4 == 3) ? 0 : pick_gap();
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        book.take_byte(b);
        sent++;
    endtask

    function automatic logic [7:0] data_byte();
        // now and then an end-of-sysex byte, which PC and CC take as data
        if ($urandom_range(0, 15) == 0) return SYSEX_STOP;
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] abort_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(128, 255)); while (b == SYSEX_STOP);
        return b;
    endfunction

    task automatic send_long_sysex(int n_data, logic [7:0] last);
        send_byte(SYSEX_START);
        repeat (n_data) send_byte(8'($urandom_range(0, 127)));
        send_byte(last);
    endtask

    task automatic send_random_message();
        int         pick;
        int         n;
        logic [7:0] ch;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 15));
        if (pick < 20) begin
            send_byte(PROG_CHG_HI | ch);
            send_byte(data_byte());
        end else if (pick < 45) begin
            send_byte(CTRL_CHG_HI | ch);
            send_byte(data_byte());
            send_byte(data_byte());
        end else if (pick < 60) begin
            send_byte(SYSEX_START);
            repeat ($urandom_range(0, 12)) send_byte(8'($urandom_range(0, 127)));
            send_byte(SYSEX_STOP);
        end else if (pick < 68) begin
            send_byte(SENSE_CODE);
        end else if (pick < 80) begin
            // start a message and break it off with a status byte
            n = $urandom_range(0, 2);
            if (n == 0) begin
                send_byte(PROG_CHG_HI | ch);
            end else if (n == 1) begin
                send_byte(CTRL_CHG_HI | ch);
                repeat ($urandom_range(0, 1)) send_byte(data_byte());
            end else begin
                send_byte(SYSEX_START);
                repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 127)));
            end
            send_byte(abort_byte());
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Result side: check each item, stall at random, hold off once for long
    initial begin : result_sink
        t_result got;
        int      stall;
        int      hold;
        bit      held_once;
        stall     = 0;
        hold      = 0;
        held_once = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_res_valid && i_res_ready) begin
                got.event_res    = t_event'(o_event_res);
                got.channel      = o_channel;
                got.first_data   = o_first_data;
                got.second_data  = o_second_data;
                got.sysex_length = o_sysex_length;
                got.store_valid  = o_store_valid;
                got.store_index  = o_store_index;
                got.store_byte   = o_store_byte;
                book.check_event(got);
            end
            if (hold > 0) begin
                hold--;
                i_res_ready <= 1'b0;
            end else if (!held_once && book.checked >= 300) begin
                held_once = 1'b1;
                hold      = HOLD_CYCLES;
                i_res_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                i_res_ready <= 1'b0;
            end else begin
                i_res_ready <= 1'b1;
                stall = ((cycles / 500) % 4 == 1) ? 0 : pick_gap();
            end
        end
    end

    initial begin : byte_source
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // data bytes while idle
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(PROG_CHG_HI | 8'h05);
        send_byte(8'h7F);
        send_byte(CTRL_CHG_HI | 8'h0F);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(SYSEX_START);
        send_byte(8'h01);
        send_byte(SYSEX_STOP);
        send_byte(SENSE_CODE);
        // status bytes that start nothing, and a program change broken off by one
        send_byte(SYSEX_STOP);
        send_byte(8'hF8);
        send_byte(8'h90);
        send_byte(PROG_CHG_HI);
        send_byte(8'h90);
        // end-of-sysex taken as data
        send_byte(PROG_CHG_HI | 8'h01);
        send_byte(SYSEX_STOP);
        send_byte(CTRL_CHG_HI | 8'h02);
        send_byte(SYSEX_STOP);
        send_byte(SYSEX_STOP);
        send_byte(SYSEX_START);
        send_byte(SENSE_CODE);
        send_byte(SYSEX_START);
        send_byte(SYSEX_STOP);

        k = 0;
        while (sent < TOTAL_BYTES) begin
            if (k == 20) begin
                // fills the buffer exactly
                send_long_sysex(SYSEX_DEPTH - 2, SYSEX_STOP);
            end else if (k == 60) begin
                send_long_sysex(SYSEX_DEPTH - 1, 8'h55);
            end else if (k == 100) begin
                send_long_sysex(SYSEX_DEPTH - 1, SYSEX_STOP);
            end else if (k == 40) begin
                // drain the block before going on
                i_rx_valid <= 1'b0;
                while (book.outstanding() != 0) @(posedge i_clk);
                send_random_message();
            end else begin
                send_random_message();
            end
            k++;
        end
        i_rx_valid <= 1'b0;

        while (book.outstanding() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (book.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
